// File: rtl/linear_interp_resampler_pcm16_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resampler unit
// Shared check forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_PCM16_UNIT_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_PCM16_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define LIR_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("check failed");

// next-cycle implication
`define LIR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("check failed");

`endif

// File: rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Types, constants and sample helpers for the resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

	localparam logic [1:0] FMT_INT16 = 2'd0;
	localparam logic [1:0] FMT_INT24 = 2'd1;
	localparam logic [1:0] FMT_INT32 = 2'd2;
	localparam logic [1:0] FMT_FLT32 = 2'd3;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_STEREO = 2'd1;
	localparam logic [1:0] REG_STEP   = 2'd2;
	localparam logic [1:0] REG_RATIO  = 2'd3;

	localparam int RES_LIMIT = 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MID,
		ST_TAIL,
		ST_CLOSE
	} lir_state_t;

	// lane request: one interpolation point
	typedef struct packed {
		logic               vld;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic [15:0]        frac;
		logic               last;
	} lir_lane_req_t;

	// decode raw sample bits to Q4.28
	function automatic logic signed [31:0] decode_sample(input logic [1:0] fmt,
		input logic [31:0] raw);
		logic [7:0]  e;
		logic [23:0] m;
		logic [31:0] mag;
		logic signed [31:0] r;
		begin
			e   = raw[30:23];
			m   = {1'b1, raw[22:0]};
			mag = '0;
			r   = '0;
			unique case (fmt)
				FMT_INT16: r = {{3{raw[15]}}, raw[15:0], 13'd0};
				FMT_INT24: r = {{3{raw[23]}}, raw[23:0], 5'd0};
				FMT_INT32: r = {{3{raw[31]}}, raw[31:3]};
				FMT_FLT32: begin
					if (e == 8'hFF && raw[22:0] != '0) r = '0;
					else if (e == 8'd0) r = '0;
					else if (e >= 8'd130) r = raw[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					else begin
						if (e >= 8'd122) mag = {8'd0, m} << (e - 8'd122);
						else if ((8'd122 - e) >= 8'd24) mag = '0;
						else mag = {8'd0, m} >> (8'd122 - e);
						r = raw[31] ? -$signed(mag) : $signed(mag);
					end
				end
				default: r = '0;
			endcase
			decode_sample = r;
		end
	endfunction

	// clamp to +-1, scale by 32767, round ties to even
	function automatic logic [15:0] to_pcm(input logic signed [32:0] x);
		logic signed [32:0] c;
		logic signed [48:0] y;
		logic signed [20:0] q;
		logic [27:0] r;
		begin
			c = x;
			if (c > 33'sd268435456) c = 33'sd268435456;
			if (c < -33'sd268435456) c = -33'sd268435456;
			y = c * 49'sd32767;
			q = y[48:28];
			r = y[27:0];
			if (r > 28'h800_0000 || (r == 28'h800_0000 && q[0])) q = q + 21'sd1;
			to_pcm = q[15:0];
		end
	endfunction

endpackage

// File: rtl/linear_interp_resampler_pcm16_unit.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_pcm16_unit
// Linear interpolation resampler to stereo 16-bit PCM, two channel lanes.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_stall   | left_raw right_raw last_frame output_room
//  out     | out_valid/out_stall | left_pcm right_pcm packet_end
//  cfg     | cfg_we              | cfg_index cfg_data
// A non-final source frame holds the input while its mid outputs issue (up to 64
// per frame); a packet's final frame also passes through the tail and close states.
// Outputs leave through the 2-stage lane pipe and the merge register. Output stalls
// hold the whole lane pipe and the sequencer's mid and tail states.
// Reset clears control state and registers to their documented values.
`include "linear_interp_resampler_pcm16_unit_defines.svh"
module linear_interp_resampler_pcm16_unit
	import lir_pkg::*;
#(
	parameter int MAX_PACKET_FRAMES = 65535,
	parameter int MAX_RATIO = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] left_raw,
	input  logic [31:0] right_raw,
	input  logic        last_frame,
	input  logic [15:0] output_room,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] left_pcm,
	output logic [15:0] right_pcm,
	output logic        packet_end
);

	localparam logic [20:0] RATIO_CAP = 21'(MAX_RATIO) << 16;
	localparam logic [15:0] FRAME_CAP = 16'(MAX_PACKET_FRAMES - 1);

	logic [1:0]  fmt_q;
	logic        stereo_q;
	logic [22:0] step_q;
	logic [20:0] ratio_q;

	lir_state_t state_q, state_d;
	logic signed [31:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
	logic [15:0] idx_q;
	logic [31:0] pos_q;
	logic [15:0] emit_q;
	logic [15:0] room_q;
	logic [15:0] bound_q;
	logic        last_q;
	logic [6:0]  cnt_q;

	logic        adv;
	logic        acc;
	logic signed [31:0] dl, dr;
	logic [15:0] ridx;
	logic        lastin;
	logic [36:0] tprod;
	logic [20:0] rcap;
	logic [20:0] target;
	logic [15:0] tgt16;
	logic [15:0] bnd;
	logic [32:0] pnext;
	logic [31:0] base;
	logic [31:0] limit;
	logic [15:0] frac;
	logic        mid_go, tail_go, issue;
	logic        end_mark;
	lir_lane_req_t req_l, req_r;
	logic        lv2, ll2, rv2, rl2;
	logic [15:0] lp2, rp2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_INT16;
			stereo_q <= 1'b1;
			step_q   <= 23'd65536;
			ratio_q  <= 21'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT: fmt_q    <= cfg_data[1:0];
				REG_STEREO: stereo_q <= cfg_data[0];
				REG_STEP:   step_q   <= cfg_data;
				REG_RATIO:  ratio_q  <= cfg_data[20:0];
				default:    fmt_q    <= fmt_q;
			endcase
		end
	end

	// input decode and output count
	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign dl       = decode_sample(fmt_q, left_raw);
	assign dr       = stereo_q ? decode_sample(fmt_q, right_raw) : dl;
	assign ridx     = (idx_q == 16'd0) ? output_room : room_q;
	assign lastin   = last_frame || (idx_q >= FRAME_CAP);
	assign rcap     = (ratio_q > RATIO_CAP) ? RATIO_CAP : ratio_q;
	assign tprod    = ({21'd0, idx_q} + 37'd1) * {16'd0, rcap} + 37'h8000;
	assign target   = (tprod[36:16] == 21'd0) ? 21'd1 : tprod[36:16];
	assign tgt16    = (target > 21'({5'd0, ridx})) ? ridx : target[15:0];
	assign bnd      = lastin ? tgt16 : ridx;

	// interpolation position for the sequencer
	assign limit  = {idx_q, 16'd0};
	assign base   = {idx_q - 16'd1, 16'd0};
	assign frac   = (pos_q >= base) ? 16'(pos_q - base) : 16'd0;
	assign pnext  = {1'b0, pos_q} + {10'd0, step_q};
	assign mid_go = (idx_q != 16'd0) && (emit_q < bound_q) && (cnt_q < 7'(RES_LIMIT))
		&& (pos_q < limit);
	assign tail_go = (emit_q < bound_q) && (cnt_q < 7'(RES_LIMIT));
	assign issue   = adv && ((state_q == ST_MID && (mid_go || (last_q && tail_go)))
		|| (state_q == ST_TAIL && tail_go));

	// marks final output of the packet
	always_comb begin
		end_mark = 1'b0;
		if (last_q && issue) begin
			end_mark = (emit_q + 16'd1 >= bound_q) || (cnt_q == 7'(RES_LIMIT - 1));
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (acc) state_d = ST_MID;
			ST_MID:   if (adv && !mid_go) state_d = last_q ? ST_TAIL : ST_IDLE;
			ST_TAIL:  if (adv && !tail_go) state_d = ST_CLOSE;
			ST_CLOSE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			cur_l_q  <= '0;
			cur_r_q  <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			emit_q   <= '0;
			room_q   <= '0;
			bound_q  <= '0;
			last_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (acc) begin
				prev_l_q <= cur_l_q;
				prev_r_q <= cur_r_q;
				cur_l_q  <= dl;
				cur_r_q  <= dr;
				room_q   <= ridx;
				bound_q  <= bnd;
				last_q   <= lastin;
				cnt_q    <= '0;
			end
			if (issue) begin
				cnt_q  <= cnt_q + 7'd1;
				emit_q <= emit_q + 16'd1;
				pos_q  <= pnext[32] ? 32'hFFFF_FFFF : pnext[31:0];
			end
			if (state_q == ST_MID && adv && !mid_go && !last_q) begin
				idx_q <= idx_q + 16'd1;
			end
			if (state_q == ST_CLOSE) begin
				idx_q  <= '0;
				pos_q  <= '0;
				emit_q <= '0;
			end
		end
	end

	// lane requests: mid outputs interpolate, tail outputs hold current frame
	always_comb begin
		req_l.vld  = issue;
		req_l.last = end_mark;
		req_r.vld  = issue;
		req_r.last = end_mark;
		if (state_q == ST_MID && mid_go) begin
			req_l.a = prev_l_q; req_l.b = cur_l_q; req_l.frac = frac;
			req_r.a = prev_r_q; req_r.b = cur_r_q; req_r.frac = frac;
		end else begin
			req_l.a = cur_l_q; req_l.b = cur_l_q; req_l.frac = 16'd0;
			req_r.a = cur_r_q; req_r.b = cur_r_q; req_r.frac = 16'd0;
		end
	end

	lir_lane u_lane_l (.clk, .arst_n, .adv, .req(req_l),
		.vld_s2(lv2), .last_s2(ll2), .pcm_s2(lp2));
	lir_lane u_lane_r (.clk, .arst_n, .adv, .req(req_r),
		.vld_s2(rv2), .last_s2(rl2), .pcm_s2(rp2));

	lir_merge u_merge (.clk, .arst_n, .l_vld(lv2 && rv2), .l_last(ll2 && rl2),
		.l_pcm(lp2), .r_pcm(rp2), .stall(out_stall), .adv,
		.valid(out_valid), .left_pcm, .right_pcm, .packet_end);

	`LIR_ASSERT_IMP(a_lanes_agree, clk, arst_n, 1'b1, lv2 == rv2)
	`LIR_ASSERT_IMP(a_no_issue_idle, clk, arst_n, state_q == ST_IDLE, !issue)
	`LIR_ASSERT_NEXT(a_close_idle, clk, arst_n, state_q == ST_CLOSE, state_q == ST_IDLE)

endmodule

// File: rtl/lir_lane.sv
// ----------------------------------------------------------------------------
// lir_lane
// One channel lane: interpolation multiply, then PCM conversion.
// ----------------------------------------------------------------------------
module lir_lane
	import lir_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  lir_lane_req_t req,
	output logic          vld_s2,
	output logic          last_s2,
	output logic [15:0]   pcm_s2
);

	logic signed [32:0] a_s1;
	logic signed [49:0] prod_s1;
	logic               vld_s1;
	logic               last_s1;
	logic signed [32:0] y;

	// stage 1: fraction times difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= 33'(req.a);
			prod_s1 <= $signed({1'b0, req.frac}) * (33'(req.b) - 33'(req.a));
			last_s1 <= req.last;
		end
	end

	// floor shift, add base
	assign y = a_s1 + 33'(prod_s1 >>> 16);

	// stage 2: convert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pcm_s2  <= to_pcm(y);
			last_s2 <= last_s1;
		end
	end

endmodule

// File: rtl/lir_merge.sv
// ----------------------------------------------------------------------------
// lir_merge
// Joins both lanes into one output item in a single output register.
// ----------------------------------------------------------------------------
module lir_merge
	import lir_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        l_vld,
	input  logic        l_last,
	input  logic [15:0] l_pcm,
	input  logic [15:0] r_pcm,
	input  logic        stall,
	output logic        adv,
	output logic        valid,
	output logic [15:0] left_pcm,
	output logic [15:0] right_pcm,
	output logic        packet_end
);

	// pipe moves when the output register is free or being taken
	assign adv = !valid || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (adv) begin
			valid <= l_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_pcm   <= l_pcm;
			right_pcm  <= r_pcm;
			packet_end <= l_last;
		end
	end

endmodule

// File: dv/tb_linear_interp_resampler_pcm16_unit.sv
// ----------------------------------------------------------------------------
// Resampler unit testbench
// Drives source frames in packets under several register settings, predicts
// every output frame with a behavioral model and checks each one in order.
// ----------------------------------------------------------------------------

// In-order store of predicted output frames, checked as the block emits them.
class pcm_frame_board;
	logic [15:0] exp_left[$];
	logic [15:0] exp_right[$];
	logic        exp_end[$];
	int          mismatches;
	int          checked;

	function new();
		mismatches = 0;
		checked = 0;
	endfunction

	// note one frame predicted from an accepted source item
	function void note_frame(logic [15:0] l, logic [15:0] r, logic e);
		exp_left.push_back(l);
		exp_right.push_back(r);
		exp_end.push_back(e);
	endfunction

	// compare one emitted frame with the oldest prediction
	function void check_frame(logic [15:0] l, logic [15:0] r, logic e);
		logic [15:0] el;
		logic [15:0] er;
		logic        ee;
		if (exp_left.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected output frame: l=%h r=%h end=%b", l, r, e);
			return;
		end
		el = exp_left.pop_front();
		er = exp_right.pop_front();
		ee = exp_end.pop_front();
		checked++;
		if (l !== el || r !== er || e !== ee) begin
			mismatches++;
			if (mismatches <= 10)
				$display("frame %0d mismatch: exp l=%h r=%h end=%b got l=%h r=%h end=%b",
					checked, el, er, ee, l, r, e);
		end
	endfunction

	function int pending();
		return exp_left.size();
	endfunction
endclass

module tb_linear_interp_resampler_pcm16_unit;
	import lir_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PKT_MAX = 65535;
	localparam int RATIO_CAP = 31;
	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [22:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] left_raw = '0;
	logic [31:0] right_raw = '0;
	logic        last_frame = 1'b0;
	logic [15:0] output_room = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] left_pcm;
	logic [15:0] right_pcm;
	logic        packet_end;

	linear_interp_resampler_pcm16_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_raw(left_raw), .right_raw(right_raw),
		.last_frame(last_frame), .output_room(output_room),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_pcm(left_pcm), .right_pcm(right_pcm), .packet_end(packet_end)
	);

	always #4 clk = ~clk;

	pcm_frame_board board = new();

	// predictor copy of registers and state
	logic [1:0]         m_fmt;
	logic               m_stereo;
	logic [22:0]        m_step;
	logic [20:0]        m_ratio;
	logic signed [63:0] m_prev_l, m_prev_r;
	logic [15:0]        m_idx;
	logic [32:0]        m_pos;
	logic [15:0]        m_emitted;
	logic [15:0]        m_room;

	bit   calm;        // no idling in the final stretch
	int   cycles;
	int   items_sent;
	int   packets_done;

	function automatic logic signed [63:0] floor_shift(logic signed [63:0] x, int s);
		return x >>> s;
	endfunction

	function automatic logic signed [63:0] to_q428(logic [31:0] raw);
		logic [7:0]         ex;
		logic [63:0]        man;
		logic signed [63:0] mag;
		case (m_fmt)
			FMT_INT16: return 64'(signed'(raw[15:0])) * 8192;
			FMT_INT24: return 64'(signed'(raw[23:0])) * 32;
			FMT_INT32: return floor_shift(64'(signed'(raw)), 3);
			default: begin
				ex = raw[30:23];
				man = {40'd0, 1'b1, raw[22:0]};
				if (ex == 8'hFF && raw[22:0] != 0) return 0;
				if (ex == 0) return 0;
				if (ex >= 130) return raw[31] ? -64'sd2147483648 : 64'sd2147483647;
				if (ex >= 122) mag = man << (ex - 122);
				else if (122 - ex >= 24) mag = 0;
				else mag = man >> (122 - ex);
				return raw[31] ? -mag : mag;
			end
		endcase
	endfunction

	function automatic logic [15:0] q428_to_pcm(logic signed [63:0] x);
		logic signed [63:0] y, q, r;
		if (x > 64'sd268435456) x = 64'sd268435456;
		if (x < -64'sd268435456) x = -64'sd268435456;
		y = x * 32767;
		q = y >>> 28;
		r = y - (q <<< 28);
		if (r > 64'sd134217728 || (r == 64'sd134217728 && q[0])) q = q + 1;
		return q[15:0];
	endfunction

	function automatic logic signed [63:0] blend(logic signed [63:0] a,
		logic signed [63:0] b, logic [63:0] frac);
		return a + floor_shift(signed'(frac) * (b - a), 16);
	endfunction

	function automatic void push_out(logic signed [63:0] l, logic signed [63:0] r);
		board.note_frame(q428_to_pcm(l), q428_to_pcm(r), 1'b0);
		m_pos = m_pos + 33'(m_step);
		if (m_pos > 33'hFFFF_FFFF) m_pos = 33'hFFFF_FFFF;
		m_emitted++;
	endfunction

	// predict the output frames one accepted source frame gives
	function automatic void predict_frame(logic [31:0] lr, logic [31:0] rr,
		logic lf, logic [15:0] room);
		logic signed [63:0] cl, cr;
		logic [63:0]        i, bound, ratio, target, lim, base, frac;
		bit                 fin;
		int                 cnt;
		cl = to_q428(lr);
		cr = m_stereo ? to_q428(rr) : cl;
		i = 64'(m_idx);
		cnt = 0;
		if (i == 0) m_room = room;
		fin = lf || i >= PKT_MAX - 1;
		bound = 64'(m_room);
		if (fin) begin
			ratio = 64'(m_ratio);
			if (ratio > (RATIO_CAP << 16)) ratio = RATIO_CAP << 16;
			target = ((i + 1) * ratio + 64'h8000) >> 16;
			if (target < 1) target = 1;
			if (target < bound) bound = target;
		end
		if (i >= 1) begin
			lim = i << 16;
			base = (i - 1) << 16;
			while (m_emitted < bound && cnt < RES_LIMIT && m_pos < lim) begin
				frac = m_pos >= base ? m_pos - base : 0;
				push_out(blend(m_prev_l, cl, frac), blend(m_prev_r, cr, frac));
				cnt++;
			end
		end
		if (fin) begin
			while (m_emitted < bound && cnt < RES_LIMIT) begin
				push_out(cl, cr);
				cnt++;
			end
			if (cnt > 0) board.exp_end[$] = 1'b1;
			m_idx = 0;
			m_pos = 0;
			m_emitted = 0;
		end else begin
			m_idx = 16'(i + 1);
		end
		m_prev_l = cl;
		m_prev_r = cr;
	endfunction

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: check and random stall bursts
	int stall_left = 0;
	int run_left = 0;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_frame(left_pcm, right_pcm, packet_end);
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (run_left > 0) begin
			run_left <= run_left - 1;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			run_left <= $urandom_range(0, 20);
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [22:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FORMAT: m_fmt = val[1:0];
			REG_STEREO: m_stereo = val[0];
			REG_STEP:   m_step = val;
			default:    m_ratio = val[20:0];
		endcase
	endtask

	// send one source frame; the prediction is made when it is accepted
	// valid stays high after acceptance until the next gap or drain
	task automatic send_frame(logic [31:0] lr, logic [31:0] rr, logic lf,
		logic [15:0] room);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_raw <= lr;
		right_raw <= rr;
		last_frame <= lf;
		output_room <= room;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_frame(lr, rr, lf, room);
		items_sent++;
		if (lf) packets_done++;
	endtask

	// let all predicted frames drain, then the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_sample();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(0, 5))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: if (m_fmt == FMT_FLT32) v = {v[31], 8'($urandom_range(100, 131)), v[22:0]};
			default: ;
		endcase
		return v;
	endfunction

	// packet of random length with random content
	task automatic send_packet(int len, logic [15:0] room);
		for (int k = 0; k < len; k++)
			send_frame(rand_sample(), rand_sample(), k == len - 1, room);
	endtask

	logic [22:0] steps[6] = '{23'd2115, 23'd65536, 23'd32768, 23'd98304,
		23'd4194304, 23'd21845};
	logic [22:0] ratios[6] = '{23'd2048, 23'd65536, 23'd131072, 23'd43691,
		23'd2031616, 23'd196608};

	initial begin
		int len;
		calm = 0;
		cycles = 0;
		items_sent = 0;
		packets_done = 0;
		m_fmt = FMT_INT16;
		m_stereo = 1'b1;
		m_step = 23'd65536;
		m_ratio = 21'd65536;
		m_prev_l = 0;
		m_prev_r = 0;
		m_idx = 0;
		m_pos = 0;
		m_emitted = 0;
		m_room = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: reset settings, extremes of int16, zero and small room
		send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b0, 16'hFFFF);
		send_frame(32'hFFFF_8000, 32'h0000_7FFF, 1'b0, 16'd0);
		send_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 16'd0);
		send_frame(32'h1234_5678, 32'h0, 1'b0, 16'd0);
		send_frame(32'h0, 32'h1, 1'b1, 16'd0);
		send_frame(32'h0000_4000, 32'h0000_C000, 1'b1, 16'd1);
		send_frame(32'h0000_4000, 32'h0000_C000, 1'b0, 16'd2);
		send_frame(32'h0000_1000, 32'h0000_2000, 1'b0, 16'd2);
		send_frame(32'h0000_1000, 32'h0000_2000, 1'b1, 16'd2);
		drain();

		// float specials, mono, high-ratio upsampling
		write_reg(REG_FORMAT, 23'(FMT_FLT32));
		write_reg(REG_STEREO, 23'd0);
		write_reg(REG_STEP, 23'd2115);
		write_reg(REG_RATIO, 23'd2031616);
		send_frame(32'h7F80_0000, 32'h0, 1'b0, 16'hFFFF);
		send_frame(32'hFF80_0000, 32'h0, 1'b0, 16'hFFFF);
		send_frame(32'h7FC0_0001, 32'h0, 1'b0, 16'hFFFF);
		send_frame(32'h0000_0001, 32'h0, 1'b0, 16'hFFFF);
		send_frame(32'h4100_0000, 32'h0, 1'b0, 16'hFFFF);
		send_frame(32'hC0FF_FFFF, 32'h0, 1'b0, 16'hFFFF);
		send_frame(32'h3F80_0000, 32'h0, 1'b0, 16'hFFFF);
		send_frame(32'h3380_0000, 32'h0, 1'b1, 16'hFFFF);
		drain();

		// int24 and int32 extremes, large step
		write_reg(REG_FORMAT, 23'(FMT_INT24));
		write_reg(REG_STEREO, 23'd1);
		write_reg(REG_STEP, 23'd4194304);
		write_reg(REG_RATIO, 23'd2048);
		send_frame(32'hFF7F_FFFF, 32'h0080_0000, 1'b0, 16'd5);
		send_frame(32'h0080_0000, 32'hFF7F_FFFF, 1'b1, 16'd5);
		drain();
		write_reg(REG_FORMAT, 23'(FMT_INT32));
		send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd9);
		send_frame(32'hFFFF_FFFF, 32'h0000_0007, 1'b0, 16'd9);
		send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'd9);
		drain();

		// random phases across settings
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_FORMAT, 23'($urandom_range(0, 3)));
			write_reg(REG_STEREO, 23'($urandom_range(0, 1)));
			write_reg(REG_STEP, ph < 6 ? steps[ph] : 23'($urandom_range(2115, 200000)));
			write_reg(REG_RATIO, ph < 6 ? ratios[5 - ph] : 23'($urandom_range(2048, 300000)));
			if (ph == 10) calm = 1;
			for (int p = 0; p < 6; p++) begin
				len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : $urandom_range(2, 6);
				send_packet(len, $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 3))
					: ($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom())));
			end
			drain();
		end

		repeat (100) @(posedge clk);
		$display("covered %0d source frames in %0d packets, %0d output frames checked",
			items_sent, packets_done, board.checked);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/lir_pkg.sv
rtl/lir_lane.sv
rtl/lir_merge.sv
rtl/linear_interp_resampler_pcm16_unit.sv
dv/tb_linear_interp_resampler_pcm16_unit.sv
